// File: design/kfct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kfct_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned FAIL_W        = 16;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned THR_W         = 16;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // stream and configuration port widths
  localparam int unsigned S_TDATA_W  = 112;
  localparam int unsigned S_TUSER_W  = 3;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // register reset values
  localparam logic [TIME_W-1:0] EXPIRE_AGE_RST     = 48'd30000000;
  localparam logic [TIME_W-1:0] SWEEP_INTERVAL_RST = 48'd60000000;
  localparam logic [THR_W-1:0]  FALLBACK_THR_RST   = 16'd3;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD = 2'd0,
    REQ_RESET  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_SWEEP  = 2'd3
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPIRE_AGE     = 2'd0,
    CFG_SWEEP_INTERVAL = 2'd1,
    CFG_FALLBACK_THR   = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // one table slot as held in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [FAIL_W-1:0] fail;
    logic [TIME_W-1:0] stamp;
  } slot_t;

  // verdict of the slot compare unit for one slot
  typedef struct packed {
    logic expired;
    logic live;
    logic match;
    logic older;
  } eval_t;

endpackage

`default_nettype wire

// File: design/kfct_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module kfct_mem (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire  [kfct_pkg::IDX_W-1:0]       waddr_i,
  input  kfct_pkg::slot_t                  wdata_i,
  input  wire                              re_i,
  input  wire  [kfct_pkg::IDX_W-1:0]       raddr_i,
  output kfct_pkg::slot_t                  rdata_o
);

  kfct_pkg::slot_t mem_q [kfct_pkg::TABLE_ENTRIES];
  kfct_pkg::slot_t rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/kfct_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module kfct_eval (
  input  kfct_pkg::slot_t                  slot_i,
  input  wire                              slot_valid_i,
  input  wire                              sweep_en_i,
  input  wire  [kfct_pkg::TIME_W-1:0]      now_i,
  input  wire  [kfct_pkg::TIME_W-1:0]      expire_age_i,
  input  wire  [kfct_pkg::KEY_W-1:0]       key_i,
  input  wire                              key_valid_i,
  input  wire                              old_valid_i,
  input  wire  [kfct_pkg::TIME_W-1:0]      old_stamp_i,
  output kfct_pkg::eval_t                  eval_o
);

  logic [kfct_pkg::TIME_W-1:0] age;
  logic                        in_past;

  // age of the slot, only meaningful when its stamp is not in the future
  assign age     = now_i - slot_i.stamp;
  assign in_past = (now_i >= slot_i.stamp);

  always_comb begin
    eval_o.expired = sweep_en_i && slot_valid_i && in_past && (age > expire_age_i);
    eval_o.live    = slot_valid_i && !eval_o.expired;
    eval_o.match   = eval_o.live && key_valid_i && (slot_i.key == key_i);
    eval_o.older   = eval_o.live && (!old_valid_i || (slot_i.stamp < old_stamp_i));
  end

endmodule

`default_nettype wire

// File: design/keyed_failure_count_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyed failure count table: TABLE_ENTRIES slots of key id, saturating failure
// count and last-update stamp. Each request (record, reset, query, sweep) is
// taken when s_axis_tready is high and gives exactly one result. The block then
// walks the slot memory one slot per cycle through its single read port, with
// one shared compare unit doing expiry, key match and oldest-stamp search. A
// request passes through a set-up state, a scan state that covers the registered
// read, and a commit state that waits while an earlier result is still held.
// s_axis_tready is low from acceptance to the commit and returns the cycle after
// the commit; a waiting result does not block the next request until its own
// commit. Configuration writes are always taken and must
// only be made while no request is in flight.
module keyed_failure_count_table_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // key_id [63:0], now_us [111:64]
  input  wire  [kfct_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  // req_type [1:0], key_valid [2]
  input  wire  [kfct_pkg::S_TUSER_W-1:0]        s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // fallback [0], entry_failures [16:1], evicted [17], entry_count [22:18], zero [23]
  output logic [kfct_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [kfct_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [kfct_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned N = kfct_pkg::TABLE_ENTRIES;

  // configuration
  logic [kfct_pkg::TIME_W-1:0] expire_age_q;
  logic [kfct_pkg::TIME_W-1:0] sweep_int_q;
  logic [kfct_pkg::THR_W-1:0]  fallback_thr_q;

  // sequencer and table control
  kfct_pkg::state_e            state_q, state_d;
  logic [N-1:0]                valid_q;
  logic [kfct_pkg::CNT_W-1:0]  occ_q, occ_d;
  logic [kfct_pkg::TIME_W-1:0] last_sweep_q;
  logic                        sweep_en_q;
  logic [kfct_pkg::CNT_W-1:0]  cnt_q;
  logic                        s1_vld_q;
  logic [kfct_pkg::IDX_W-1:0]  s1_idx_q;

  // request held for the duration of the walk
  kfct_pkg::req_e              req_q;
  logic [kfct_pkg::KEY_W-1:0]  key_q;
  logic                        kv_q;
  logic [kfct_pkg::TIME_W-1:0] now_q;

  // search results
  logic                        match_vld_q;
  logic [kfct_pkg::IDX_W-1:0]  match_idx_q;
  logic [kfct_pkg::FAIL_W-1:0] match_fail_q;
  logic                        free_vld_q;
  logic [kfct_pkg::IDX_W-1:0]  free_idx_q;
  logic                        old_vld_q;
  logic [kfct_pkg::IDX_W-1:0]  old_idx_q;
  logic [kfct_pkg::TIME_W-1:0] old_stamp_q;

  // result register
  logic                          m_valid_q;
  logic [kfct_pkg::M_TDATA_W-1:0] m_data_q;

  // internal nets
  logic                        in_fire;
  logic                        cfg_fire;
  logic                        scan_more;
  logic                        rd_en;
  kfct_pkg::slot_t             rd_slot;
  kfct_pkg::eval_t             ev;
  logic                        sweep_go;
  logic [kfct_pkg::TIME_W-1:0] since_sweep;
  logic                        out_free;
  logic                        commit_go;
  logic                        full;
  logic [kfct_pkg::FAIL_W-1:0] inc_fail;
  logic                        we;
  logic [kfct_pkg::IDX_W-1:0]  waddr;
  kfct_pkg::slot_t             wslot;
  logic                        set_vld;
  logic                        clr_vld;
  logic [kfct_pkg::IDX_W-1:0]  vaddr;
  logic                        fb;
  logic                        evict;
  logic [kfct_pkg::FAIL_W-1:0] fails;

  // handshakes
  assign s_axis_tready = (state_q == kfct_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit_go     = (state_q == kfct_pkg::ST_COMMIT) && out_free;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // lazy sweep decision for a record, explicit sweep always
  assign since_sweep = now_q - last_sweep_q;
  assign sweep_go    = (req_q == kfct_pkg::REQ_SWEEP) ||
                       ((req_q == kfct_pkg::REQ_RECORD) && kv_q &&
                        (now_q >= last_sweep_q) && (since_sweep >= sweep_int_q));

  // slot walk read side
  assign scan_more = (cnt_q < kfct_pkg::CNT_W'(N));
  assign rd_en     = (state_q == kfct_pkg::ST_SCAN) && scan_more;

  kfct_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wslot),
    .re_i    (rd_en),
    .raddr_i (cnt_q[kfct_pkg::IDX_W-1:0]),
    .rdata_o (rd_slot)
  );

  kfct_eval u_eval (
    .slot_i       (rd_slot),
    .slot_valid_i (valid_q[s1_idx_q]),
    .sweep_en_i   (sweep_en_q),
    .now_i        (now_q),
    .expire_age_i (expire_age_q),
    .key_i        (key_q),
    .key_valid_i  (kv_q),
    .old_valid_i  (old_vld_q),
    .old_stamp_i  (old_stamp_q),
    .eval_o       (ev)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_age_q   <= kfct_pkg::EXPIRE_AGE_RST;
      sweep_int_q    <= kfct_pkg::SWEEP_INTERVAL_RST;
      fallback_thr_q <= kfct_pkg::FALLBACK_THR_RST;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        kfct_pkg::CFG_EXPIRE_AGE:     expire_age_q   <= cfg_data_i[kfct_pkg::TIME_W-1:0];
        kfct_pkg::CFG_SWEEP_INTERVAL: sweep_int_q    <= cfg_data_i[kfct_pkg::TIME_W-1:0];
        kfct_pkg::CFG_FALLBACK_THR:   fallback_thr_q <= cfg_data_i[kfct_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfct_pkg::ST_IDLE: begin
        if (in_fire) state_d = kfct_pkg::ST_PREP;
      end
      kfct_pkg::ST_PREP: begin
        state_d = kfct_pkg::ST_SCAN;
      end
      kfct_pkg::ST_SCAN: begin
        if (!scan_more && s1_vld_q) state_d = kfct_pkg::ST_COMMIT;
      end
      kfct_pkg::ST_COMMIT: begin
        if (out_free) state_d = kfct_pkg::ST_IDLE;
      end
      default: state_d = kfct_pkg::ST_IDLE;
    endcase
  end

  // commit decision from the search results
  assign full     = (occ_q >= kfct_pkg::CNT_W'(N));
  assign inc_fail = (match_fail_q == '1) ? match_fail_q : match_fail_q + 1'b1;

  always_comb begin
    we          = 1'b0;
    waddr       = free_idx_q;
    wslot.key   = key_q;
    wslot.fail  = kfct_pkg::FAIL_W'(1);
    wslot.stamp = now_q;
    set_vld     = 1'b0;
    clr_vld     = 1'b0;
    vaddr       = free_idx_q;
    occ_d       = occ_q;
    fb          = 1'b0;
    evict       = 1'b0;
    fails       = '0;
    case (req_q)
      kfct_pkg::REQ_RECORD: begin
        if (kv_q) begin
          if (match_vld_q) begin
            // bump the matching entry
            we         = commit_go;
            waddr      = match_idx_q;
            wslot.fail = inc_fail;
            fails      = inc_fail;
          end else if (full && old_vld_q) begin
            // replace the oldest entry in place
            we    = commit_go;
            waddr = old_idx_q;
            evict = 1'b1;
            fails = kfct_pkg::FAIL_W'(1);
          end else if (free_vld_q) begin
            // insert at the lowest free slot
            we      = commit_go;
            waddr   = free_idx_q;
            set_vld = 1'b1;
            vaddr   = free_idx_q;
            occ_d   = occ_q + 1'b1;
            fails   = kfct_pkg::FAIL_W'(1);
          end
        end
      end
      kfct_pkg::REQ_RESET: begin
        if (kv_q && match_vld_q) begin
          clr_vld = 1'b1;
          vaddr   = match_idx_q;
          occ_d   = (occ_q != '0) ? occ_q - 1'b1 : occ_q;
        end
      end
      kfct_pkg::REQ_QUERY: begin
        if (kv_q) begin
          fb    = (fallback_thr_q == '0) ||
                  (match_vld_q && (match_fail_q >= fallback_thr_q));
          fails = match_vld_q ? match_fail_q : '0;
        end
      end
      default: begin
        fails = (kv_q && match_vld_q) ? match_fail_q : '0;
      end
    endcase
  end

  // table control: valid bits, occupancy, sweep time, search trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      occ_q        <= '0;
      last_sweep_q <= '0;
      sweep_en_q   <= 1'b0;
      cnt_q        <= '0;
      s1_vld_q     <= 1'b0;
      match_vld_q  <= 1'b0;
      free_vld_q   <= 1'b0;
      old_vld_q    <= 1'b0;
    end else begin
      unique case (state_q)
        kfct_pkg::ST_PREP: begin
          sweep_en_q  <= sweep_go;
          if (sweep_go) last_sweep_q <= now_q;
          cnt_q       <= '0;
          s1_vld_q    <= 1'b0;
          match_vld_q <= 1'b0;
          free_vld_q  <= 1'b0;
          old_vld_q   <= 1'b0;
        end
        kfct_pkg::ST_SCAN: begin
          s1_vld_q <= rd_en;
          if (rd_en) cnt_q <= cnt_q + 1'b1;
          if (s1_vld_q) begin
            if (ev.expired) begin
              valid_q[s1_idx_q] <= 1'b0;
              if (occ_q != '0) occ_q <= occ_q - 1'b1;
            end
            if (ev.match) match_vld_q <= 1'b1;
            if (!ev.live && !free_vld_q) free_vld_q <= 1'b1;
            if (ev.older) old_vld_q <= 1'b1;
          end
        end
        kfct_pkg::ST_COMMIT: begin
          if (commit_go) begin
            occ_q <= occ_d;
            if (set_vld) valid_q[vaddr] <= 1'b1;
            if (clr_vld) valid_q[vaddr] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // request payload and search payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= s_axis_tdata[kfct_pkg::KEY_W-1:0];
      now_q <= s_axis_tdata[kfct_pkg::KEY_W +: kfct_pkg::TIME_W];
      req_q <= kfct_pkg::req_e'(s_axis_tuser[kfct_pkg::REQ_W-1:0]);
      kv_q  <= s_axis_tuser[kfct_pkg::REQ_W];
    end
    if (rd_en) s1_idx_q <= cnt_q[kfct_pkg::IDX_W-1:0];
    if ((state_q == kfct_pkg::ST_SCAN) && s1_vld_q) begin
      if (ev.match) begin
        match_idx_q  <= s1_idx_q;
        match_fail_q <= rd_slot.fail;
      end
      if (!ev.live && !free_vld_q) free_idx_q <= s1_idx_q;
      if (ev.older) begin
        old_idx_q   <= s1_idx_q;
        old_stamp_q <= rd_slot.stamp;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      m_data_q <= {1'b0, kfct_pkg::ENTRY_COUNT_W'(occ_d), evict, fails, fb};
    end
  end

endmodule

`default_nettype wire

// File: design/kfct_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kfct_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [kfct_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("kfct: ready while a request is in flight");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("kfct: stalled result changed");

  // eviction only happens with a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[17]) |->
      (m_axis_tdata[22:18] == kfct_pkg::ENTRY_COUNT_W'(kfct_pkg::TABLE_ENTRIES)))
    else $error("kfct: eviction without a full table");

  // a record that evicts never answers a fallback
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[17]))
    else $error("kfct: fallback and eviction in one result");

endmodule

bind keyed_failure_count_table_top kfct_checker u_kfct_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// one answer as carried on m_axis_tdata bits 22:0
typedef struct packed {
  logic [4:0]  entry_count;
  logic        evicted;
  logic [15:0] entry_failures;
  logic        fallback;
} table_answer_t;

// mirror of the failure table and queue of answers still owed by the block
class failure_table_tracker;
  logic [47:0] expire_age;
  logic [47:0] sweep_interval;
  logic [15:0] threshold;
  bit          live   [kfct_pkg::TABLE_ENTRIES];
  logic [63:0] key_of [kfct_pkg::TABLE_ENTRIES];
  logic [15:0] tally  [kfct_pkg::TABLE_ENTRIES];
  logic [47:0] stamp  [kfct_pkg::TABLE_ENTRIES];
  logic [47:0] last_sweep;
  int unsigned occupied;
  table_answer_t answers_due[$];
  int unsigned mismatches;
  int unsigned answers_checked;

  function new();
    expire_age      = kfct_pkg::EXPIRE_AGE_RST;
    sweep_interval  = kfct_pkg::SWEEP_INTERVAL_RST;
    threshold       = kfct_pkg::FALLBACK_THR_RST;
    foreach (live[i]) live[i] = 1'b0;
    last_sweep      = '0;
    occupied        = 0;
    mismatches      = 0;
    answers_checked = 0;
  endfunction

  function void set_register(kfct_pkg::cfg_idx_e idx, logic [47:0] value);
    case (idx)
      kfct_pkg::CFG_EXPIRE_AGE:     expire_age = value;
      kfct_pkg::CFG_SWEEP_INTERVAL: sweep_interval = value;
      kfct_pkg::CFG_FALLBACK_THR:   threshold = value[15:0];
      default: ;
    endcase
  endfunction

  function int find_key(logic [63:0] key);
    for (int i = 0; i < kfct_pkg::TABLE_ENTRIES; i++)
      if (live[i] && key_of[i] == key) return i;
    return -1;
  endfunction

  // entries stamped in the future never expire
  function void drop_expired(logic [47:0] now);
    for (int i = 0; i < kfct_pkg::TABLE_ENTRIES; i++) begin
      if (live[i] && now >= stamp[i] && (now - stamp[i]) > expire_age) begin
        live[i] = 1'b0;
        if (occupied > 0) occupied--;
      end
    end
    last_sweep = now;
  endfunction

  // apply one accepted request and queue the answer it must give
  function void log_request(kfct_pkg::req_e kind, logic [63:0] key, logic key_ok,
                            logic [47:0] now);
    table_answer_t ans;
    int s;
    int pick;
    ans = '0;
    if (kind == kfct_pkg::REQ_RECORD && key_ok) begin
      if (now >= last_sweep && (now - last_sweep) >= sweep_interval) drop_expired(now);
      s = find_key(key);
      if (s >= 0) begin
        if (tally[s] != 16'hFFFF) tally[s]++;
        stamp[s] = now;
      end else begin
        // full table: oldest stamp goes, ties to the lowest slot
        if (occupied >= kfct_pkg::TABLE_ENTRIES) begin
          pick = -1;
          for (int i = 0; i < kfct_pkg::TABLE_ENTRIES; i++)
            if (live[i] && (pick < 0 || stamp[i] < stamp[pick])) pick = i;
          if (pick >= 0) begin
            live[pick] = 1'b0;
            if (occupied > 0) occupied--;
            ans.evicted = 1'b1;
          end
        end
        for (int i = 0; i < kfct_pkg::TABLE_ENTRIES; i++) begin
          if (!live[i]) begin
            live[i]   = 1'b1;
            key_of[i] = key;
            tally[i]  = 16'd1;
            stamp[i]  = now;
            occupied++;
            break;
          end
        end
      end
    end else if (kind == kfct_pkg::REQ_RESET && key_ok) begin
      s = find_key(key);
      if (s >= 0) begin
        live[s] = 1'b0;
        if (occupied > 0) occupied--;
      end
    end else if (kind == kfct_pkg::REQ_QUERY && key_ok) begin
      if (threshold == 16'd0) begin
        ans.fallback = 1'b1;
      end else begin
        s = find_key(key);
        if (s >= 0 && tally[s] >= threshold) ans.fallback = 1'b1;
      end
    end else if (kind == kfct_pkg::REQ_SWEEP) begin
      drop_expired(now);
    end
    if (key_ok) begin
      s = find_key(key);
      if (s >= 0) ans.entry_failures = tally[s];
    end
    ans.entry_count = 5'(occupied);
    answers_due.push_back(ans);
  endfunction

  // compare one delivered answer with the oldest one owed
  function void check_answer(logic [23:0] data);
    table_answer_t got;
    table_answer_t want;
    got = data[22:0];
    answers_checked++;
    if (answers_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual %h", $time, data);
      return;
    end
    want = answers_due.pop_front();
    if (data[23] !== 1'b0) begin
      mismatches++;
      $display("%0t: pad bit expected 0 actual %b", $time, data[23]);
    end
    if (got.fallback !== want.fallback) begin
      mismatches++;
      $display("%0t: fallback expected %b actual %b", $time, want.fallback, got.fallback);
    end
    if (got.entry_failures !== want.entry_failures) begin
      mismatches++;
      $display("%0t: entry_failures expected %0d actual %0d", $time,
               want.entry_failures, got.entry_failures);
    end
    if (got.evicted !== want.evicted) begin
      mismatches++;
      $display("%0t: evicted expected %b actual %b", $time, want.evicted, got.evicted);
    end
    if (got.entry_count !== want.entry_count) begin
      mismatches++;
      $display("%0t: entry_count expected %0d actual %0d", $time,
               want.entry_count, got.entry_count);
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned POOL_SIZE   = 24;
  localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [kfct_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [kfct_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [kfct_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [kfct_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [kfct_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  failure_table_tracker tracker = new();

  logic [63:0] key_pool [POOL_SIZE];
  logic [47:0] now_us    = '0;
  int          step_span = 50;
  int          req_gap   = 0;
  bit          no_idle   = 1'b0;

  keyed_failure_count_table_top DUT (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** keyed_failure_count_table_top: FAILED **");
    $finish;
  end

  // one request, valid kept high when the next one follows at once
  task automatic send_request(kfct_pkg::req_e kind, logic [63:0] key, logic key_ok,
                              logic [47:0] now);
    repeat (req_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, key};
    s_axis_tuser  <= {key_ok, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.log_request(kind, key, key_ok, now);
    req_gap = no_idle ? 0 : $urandom_range(0, 6);
    if (req_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic stop_requests();
    if (req_gap == 0) s_axis_tvalid <= 1'b0;
    req_gap = 0;
  endtask

  // block idle: wait for all answers, then let the block settle
  task automatic wait_drained();
    while (tracker.answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(kfct_pkg::cfg_idx_e idx, logic [47:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_register(idx, value);
  endtask

  task automatic set_config(logic [47:0] age, logic [47:0] sweep_gap, logic [15:0] thr);
    write_register(kfct_pkg::CFG_EXPIRE_AGE, age);
    write_register(kfct_pkg::CFG_SWEEP_INTERVAL, sweep_gap);
    write_register(kfct_pkg::CFG_FALLBACK_THR, {32'd0, thr});
    cfg_valid_i <= 1'b0;
  endtask

  // mostly forward time, sometimes still, backwards or far away
  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)       now_us = now_us - 48'($urandom_range(1, 500));
    else if (r < 8)  now_us = 48'({$urandom, $urandom});
    else if (r < 28) now_us = now_us;
    else             now_us = now_us + 48'($urandom_range(1, step_span));
  endtask

  task automatic random_request();
    kfct_pkg::req_e kind;
    logic [63:0]    key;
    logic           key_ok;
    int             r;
    r = $urandom_range(0, 99);
    if (r < 45)      kind = kfct_pkg::REQ_RECORD;
    else if (r < 65) kind = kfct_pkg::REQ_QUERY;
    else if (r < 85) kind = kfct_pkg::REQ_RESET;
    else             kind = kfct_pkg::REQ_SWEEP;
    if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
    else                           key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    key_ok = ($urandom_range(0, 13) != 0);
    advance_clock();
    send_request(kind, key, key_ok, now_us);
  endtask

  // result side: random stalls, some starting only once a result shows
  initial begin
    int  stall;
    bit  late;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      late  = !no_idle && ($urandom_range(0, 1) == 1);
      if (tracker.answers_checked == 150 || tracker.answers_checked == 1000) begin
        stall = HOLD_CYCLES;
        late  = 1'b0;
      end
      if (stall > 0 || late) begin
        m_axis_tready <= 1'b0;
        if (late) begin
          @(posedge clk_i);
          while (!m_axis_tvalid) @(posedge clk_i);
        end
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      tracker.check_answer(m_axis_tdata);
    end
  end

  // stimulus
  initial begin
    logic [63:0] bump_key;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    bump_key = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset register values
    send_request(kfct_pkg::REQ_QUERY,  key_pool[0], 1'b1, 48'd0);
    send_request(kfct_pkg::REQ_RECORD, 64'd0,       1'b1, 48'd0);
    send_request(kfct_pkg::REQ_RECORD, '1,          1'b1, 48'd10);
    send_request(kfct_pkg::REQ_RECORD, key_pool[0], 1'b1, 48'd20);
    send_request(kfct_pkg::REQ_RECORD, key_pool[0], 1'b1, 48'd30);
    send_request(kfct_pkg::REQ_QUERY,  key_pool[0], 1'b1, 48'd30);
    send_request(kfct_pkg::REQ_RECORD, key_pool[0], 1'b1, 48'd40);
    send_request(kfct_pkg::REQ_QUERY,  key_pool[0], 1'b1, 48'd40);
    // empty key leaves the table alone
    send_request(kfct_pkg::REQ_RECORD, key_pool[1], 1'b0, 48'd45);
    send_request(kfct_pkg::REQ_QUERY,  key_pool[0], 1'b0, 48'd45);
    send_request(kfct_pkg::REQ_RESET,  key_pool[0], 1'b0, 48'd45);
    send_request(kfct_pkg::REQ_RESET,  key_pool[0], 1'b1, 48'd50);
    send_request(kfct_pkg::REQ_RESET,  key_pool[0], 1'b1, 48'd50);
    send_request(kfct_pkg::REQ_RECORD, key_pool[2], 1'b1, 48'd20_000_000);
    // explicit sweep with an empty key
    send_request(kfct_pkg::REQ_SWEEP,  key_pool[2], 1'b0, 48'd30_000_011);
    // time going backwards
    send_request(kfct_pkg::REQ_RECORD, key_pool[1], 1'b1, 48'd25_000_000);
    send_request(kfct_pkg::REQ_SWEEP,  key_pool[1], 1'b1, 48'd26_000_000);
    send_request(kfct_pkg::REQ_RECORD, key_pool[3], 1'b1, 48'd24_000_000);
    send_request(kfct_pkg::REQ_SWEEP,  key_pool[3], 1'b1, 48'd23_000_000);
    // lazy sweep once the interval has passed
    send_request(kfct_pkg::REQ_RECORD, key_pool[4], 1'b1, 48'd86_000_001);
    send_request(kfct_pkg::REQ_RECORD, key_pool[5], 1'b1, TIME_MAX);
    send_request(kfct_pkg::REQ_QUERY,  key_pool[5], 1'b1, TIME_MAX);
    stop_requests();
    wait_drained();

    // zero threshold answers yes for any valid key
    set_config(48'd100, 48'd50, 16'd0);
    send_request(kfct_pkg::REQ_QUERY, key_pool[6], 1'b1, 48'd0);
    send_request(kfct_pkg::REQ_QUERY, key_pool[6], 1'b0, 48'd0);
    send_request(kfct_pkg::REQ_SWEEP, key_pool[6], 1'b1, 48'd0);
    now_us = 48'd1000;

    // random phases, one register setting each
    for (int p = 0; p < 6; p++) begin
      stop_requests();
      wait_drained();
      case (p)
        0: begin set_config(48'd400, 48'd100, 16'd2);        step_span = 10;  end
        1: begin set_config(48'd0, 48'd0, 16'd1);            step_span = 20;  end
        2: begin set_config(TIME_MAX, TIME_MAX, 16'hFFFF);   step_span = 50;  end
        3: begin set_config(48'd1500, 48'd300, 16'd0);       step_span = 100; end
        4: begin
          set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 16'($urandom));
          step_span = 50;
        end
        default: begin
          set_config(48'($urandom_range(50, 800)), 48'($urandom_range(0, 400)),
                     16'($urandom_range(1, 6)));
          step_span = 40;
        end
      endcase
      for (int n = 0; n < 300; n++) begin
        if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_request();
      end
    end

    // one key bumped back to back past the threshold, then asked
    stop_requests();
    no_idle = 1'b1;
    wait_drained();
    set_config(TIME_MAX, TIME_MAX, 16'd20);
    for (int n = 0; n < 24; n++)
      send_request(kfct_pkg::REQ_RECORD, bump_key, 1'b1, now_us);
    send_request(kfct_pkg::REQ_QUERY, bump_key, 1'b1, now_us);
    stop_requests();
    no_idle = 1'b0;

    // drain and settle
    while (tracker.answers_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.answers_due.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, tracker.answers_due.size());
    if (tracker.mismatches == 0 && tracker.answers_due.size() == 0) begin
      $display("** keyed_failure_count_table_top: PASSED **");
    end else begin
      $display("** keyed_failure_count_table_top: FAILED **");
    end
    $finish;
  end

endmodule
